// ----- rtl/m3i_pkg.sv -----
// shared types and constants for the 3x3 matrix inverse pipeline
`timescale 1ns / 1ps
`default_nettype none
package m3i_pkg;

  // register stages in front of the division lanes
  localparam int FRONT_STAGES = 6;

  typedef struct packed {
    logic singular;
    logic det_sat;
  } m3i_flag_t;

endpackage
`default_nettype wire

// ----- rtl/matrix3x3_inverse.sv -----
// 3x3 matrix inverse top level: front end, nine division lanes, merge and output register
// throughput: one matrix per cycle unless m_tready backpressure fills the pipeline,
// set by the fully pipelined cofactor and divider stages
// the divider lanes produce one quotient bit per stage over ELEMENT_WIDTH stages
// stages move on whenever the next one is empty, so bubbles close up under backpressure
// reset clears all stage valid bits and the output valid, the data path is not reset
`timescale 1ns / 1ps
`default_nettype none
module matrix3x3_inverse #(
  parameter int ELEMENT_WIDTH = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  // in_r0_c0, in_r0_c1, in_r0_c2, in_r1_c0 .. in_r2_c2
  input  wire logic [((9*ELEMENT_WIDTH+7)/8)*8-1:0]  s_tdata,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  // inv_r0_c0 .. inv_r2_c2, det_value
  output logic [((10*ELEMENT_WIDTH+7)/8)*8-1:0]      m_tdata,
  // singular, saturated
  output logic [1:0]                                 m_tuser
);
  import m3i_pkg::*;

  localparam int E    = ELEMENT_WIDTH;
  localparam int F    = FRACTION_BITS;
  localparam int LST  = E + 1;
  localparam int NST  = FRONT_STAGES + LST;
  localparam int OW   = ((10 * E + 7) / 8) * 8;

  logic [NST-1:0] valid;
  logic [NST:0]   adv;

  always_comb begin
    adv[NST] = !m_tvalid || m_tready;
    for (int i = NST - 1; i >= 0; i--) adv[i] = !valid[i] || adv[i+1];
  end

  assign s_tready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (adv[0]) valid[0] <= s_tvalid;
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) valid[i] <= valid[i-1];
      end
      if (adv[NST]) m_tvalid <= valid[NST-1];
    end
  end

  logic [E-1:0]       elem [9];
  logic [2*E+2*F:0]   num_mag [9];
  logic [8:0]         quo_neg;
  logic [3*E:0]       det_mag;
  logic [E-1:0]       det_field;
  m3i_flag_t          flags;

  for (genvar i = 0; i < 9; i++) begin : g_elem
    assign elem[i] = s_tdata[i*E +: E];
  end

  m3i_front #(.E(E), .F(F)) u_front (
    .clk       (clk),
    .en        (adv[FRONT_STAGES-1:0]),
    .in_elem   (elem),
    .num_mag   (num_mag),
    .quo_neg   (quo_neg),
    .det_mag   (det_mag),
    .det_field (det_field),
    .flags     (flags)
  );

  logic [E-1:0] q_field [9];
  logic [8:0]   lane_sat;

  for (genvar i = 0; i < 9; i++) begin : g_lane
    m3i_div_lane #(.E(E), .F(F)) u_lane (
      .clk     (clk),
      .en      (adv[NST-1:FRONT_STAGES]),
      .num_mag (num_mag[i]),
      .neg     (quo_neg[i]),
      .det_mag (det_mag),
      .q_field (q_field[i]),
      .sat     (lane_sat[i])
    );
  end

  // determinant and flags ride alongside the lanes
  logic [E-1:0] sb_det  [LST];
  m3i_flag_t    sb_flag [LST];

  always_ff @(posedge clk) begin
    if (adv[FRONT_STAGES]) begin
      sb_det[0]  <= det_field;
      sb_flag[0] <= flags;
    end
    for (int j = 1; j < LST; j++) begin
      if (adv[FRONT_STAGES+j]) begin
        sb_det[j]  <= sb_det[j-1];
        sb_flag[j] <= sb_flag[j-1];
      end
    end
  end

  // merge
  logic [OW-1:0] tdata_next;
  logic [1:0]    tuser_next;

  always_comb begin
    tdata_next = '0;
    if (!sb_flag[LST-1].singular) begin
      for (int i = 0; i < 9; i++) tdata_next[i*E +: E] = q_field[i];
      tdata_next[9*E +: E] = sb_det[LST-1];
    end
    tuser_next[0] = sb_flag[LST-1].singular;
    tuser_next[1] = !sb_flag[LST-1].singular && ((|lane_sat) || sb_flag[LST-1].det_sat);
  end

  always_ff @(posedge clk) begin
    if (adv[NST]) begin
      m_tdata <= tdata_next;
      m_tuser <= tuser_next;
    end
  end

  a_singular_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
    else $error("singular result with nonzero payload");

  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  a_last_stage_moves : assert property (@(posedge clk) disable iff (rst)
    valid[NST-1] && !m_tvalid |=> m_tvalid)
    else $error("finished item not moved to output register");

endmodule
`default_nettype wire

// ----- rtl/m3i_front.sv -----
// cofactors, determinant and lane operands for the 3x3 inverse
`timescale 1ns / 1ps
`default_nettype none
module m3i_front #(
  parameter int E = 32,
  parameter int F = 16
) (
  input  wire logic                              clk,
  input  wire logic [m3i_pkg::FRONT_STAGES-1:0]  en,
  input  wire logic [E-1:0]                      in_elem [9],
  output logic [2*E+2*F:0]                       num_mag [9],
  output logic [8:0]                             quo_neg,
  output logic [3*E:0]                           det_mag,
  output logic [E-1:0]                           det_field,
  output m3i_pkg::m3i_flag_t                     flags
);
  import m3i_pkg::*;

  localparam int CW  = 2 * E + 1;
  localparam int DSW = 3 * E + 2;
  localparam int DMW = 3 * E + 1;
  localparam int NMW = 2 * E + 2 * F + 1;

  logic signed [E-1:0]   a      [9];
  logic signed [2*E-1:0] pa     [9];
  logic signed [2*E-1:0] pb     [9];
  logic signed [E-1:0]   a_s2   [3];
  logic signed [CW-1:0]  cof    [9];
  logic signed [E-1:0]   a_s3   [3];
  logic signed [2*E:0]   pl     [3];
  logic signed [2*E:0]   ph     [3];
  logic signed [CW-1:0]  cof_s4 [9];
  logic signed [DSW-1:0] det;
  logic signed [CW-1:0]  cof_s5 [9];

  // input register
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 9; i++) a[i] <= in_elem[i];
    end
  end

  // minor products and cofactors
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      localparam int R1 = (r == 0) ? 1 : 0;
      localparam int R2 = (r == 2) ? 1 : 2;
      localparam int C1 = (c == 0) ? 1 : 0;
      localparam int C2 = (c == 2) ? 1 : 2;
      localparam int K  = r * 3 + c;
      always_ff @(posedge clk) begin
        if (en[1]) begin
          pa[K] <= a[R1*3+C1] * a[R2*3+C2];
          pb[K] <= a[R1*3+C2] * a[R2*3+C1];
        end
        if (en[2]) begin
          if (((r + c) % 2) == 1) cof[K] <= CW'(pb[K]) - CW'(pa[K]);
          else cof[K] <= CW'(pa[K]) - CW'(pb[K]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) a_s2[i] <= a[i];
    end
    if (en[2]) begin
      for (int i = 0; i < 3; i++) a_s3[i] <= a_s2[i];
    end
    // first-row products, cofactor split into low and high halves
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        pl[i] <= a_s3[i] * $signed({1'b0, cof[i][E-1:0]});
        ph[i] <= a_s3[i] * $signed(cof[i][CW-1:E]);
      end
      for (int i = 0; i < 9; i++) cof_s4[i] <= cof[i];
    end
    if (en[4]) begin
      det <= ((DSW'(ph[0]) <<< E) + DSW'(pl[0]))
           + ((DSW'(ph[1]) <<< E) + DSW'(pl[1]))
           + ((DSW'(ph[2]) <<< E) + DSW'(pl[2]));
      for (int i = 0; i < 9; i++) cof_s5[i] <= cof_s4[i];
    end
  end

  // sign and magnitude, determinant output field
  logic            det_neg;
  logic [DMW-1:0]  dmag;
  logic [DMW-1:0]  dsh;
  logic            dbig;
  logic [E-1:0]    du;
  logic [E-1:0]    dfield;
  logic            dsat;
  logic [E-1:0]    half;

  always_comb begin
    half    = {1'b1, {(E-1){1'b0}}};
    det_neg = det[DSW-1];
    dmag    = DMW'(det_neg ? -det : det);
    dsh     = dmag >> (2 * F);
    dbig    = |dsh[DMW-1:E];
    du      = dsh[E-1:0];
    dsat    = 1'b0;
    if (det_neg) begin
      if (dbig || du > half) begin
        dsat   = 1'b1;
        dfield = half;
      end else begin
        dfield = -du;
      end
    end else begin
      if (dbig || du[E-1]) begin
        dsat   = 1'b1;
        dfield = ~half;
      end else begin
        dfield = du;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      det_mag        <= dmag;
      det_field      <= dfield;
      flags.singular <= (det == '0);
      flags.det_sat  <= dsat;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          quo_neg[r*3+c] <= cof_s5[c*3+r][CW-1] ^ det_neg;
          num_mag[r*3+c] <= NMW'(CW'(cof_s5[c*3+r][CW-1] ? -cof_s5[c*3+r]
                                                           : cof_s5[c*3+r])) << (2 * F);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/m3i_div_lane.sv -----
// one restoring division lane, one quotient bit per stage, with saturation
`timescale 1ns / 1ps
`default_nettype none
module m3i_div_lane #(
  parameter int E = 32,
  parameter int F = 16
) (
  input  wire logic               clk,
  input  wire logic [E:0]         en,
  input  wire logic [2*E+2*F:0]   num_mag,
  input  wire logic               neg,
  input  wire logic [3*E:0]       det_mag,
  output logic [E-1:0]            q_field,
  output logic                    sat
);
  import m3i_pkg::*;

  localparam int NMW = 2 * E + 2 * F + 1;
  localparam int DMW = 3 * E + 1;
  localparam int RW  = ((NMW > DMW + E) ? NMW : DMW + E) + 1;

  logic [RW-1:0]  rem  [E];
  logic [DMW-1:0] d    [E];
  logic [E-1:0]   q    [E+1];
  logic           sg   [E+1];
  logic           big  [E+1];

  // quotient must stay below 2^E, otherwise it saturates
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0] <= RW'(num_mag);
      d[0]   <= det_mag;
      q[0]   <= '0;
      sg[0]  <= neg;
      big[0] <= RW'(num_mag) >= (RW'(det_mag) << E);
    end
  end

  for (genvar k = 1; k <= E; k++) begin : g_bit
    logic [RW-1:0] trial;
    logic          ge;
    assign trial = RW'(d[k-1]) << (E - k);
    assign ge    = rem[k-1] >= trial;
    always_ff @(posedge clk) begin
      if (en[k]) begin
        q[k]   <= {q[k-1][E-2:0], ge};
        sg[k]  <= sg[k-1];
        big[k] <= big[k-1];
      end
    end
    if (k < E) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem[k] <= ge ? rem[k-1] - trial : rem[k-1];
          d[k]   <= d[k-1];
        end
      end
    end
  end

  logic [E-1:0] half;
  always_comb begin
    half = {1'b1, {(E-1){1'b0}}};
    sat  = 1'b0;
    if (sg[E]) begin
      if (big[E] || q[E] > half) begin
        sat     = 1'b1;
        q_field = half;
      end else begin
        q_field = -q[E];
      end
    end else begin
      if (big[E] || q[E][E-1]) begin
        sat     = 1'b1;
        q_field = ~half;
      end else begin
        q_field = q[E];
      end
    end
  end

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// testbench for the 3x3 matrix inverse: directed table plus random matrices, scoreboard check
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  localparam int EW = 32;
  localparam int FB = 16;
  localparam int N_RANDOM = 1880;
  localparam int QUIET_TAIL = 200;
  localparam logic [EW-1:0] ONE = 32'h0001_0000;
  localparam logic [EW-1:0] MAXP = 32'h7fff_ffff;
  localparam logic [EW-1:0] MINN = 32'h8000_0000;

  typedef logic [9*EW-1:0] matrix_t;
  // user bits on top of the ten data fields
  typedef logic [10*EW+1:0] inverse_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  matrix_t s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [10*EW-1:0] m_tdata;
  logic [1:0] m_tuser;

  inverse_t expected_q[$];
  int errors = 0;
  int cycle = 0;
  bit quiet = 1'b0;

  matrix3x3_inverse #(.ELEMENT_WIDTH(EW), .FRACTION_BITS(FB)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [EW-1:0] clip(logic signed [127:0] v, ref logic sat);
    if (v > $signed({96'd0, MAXP})) begin
      sat = 1'b1;
      return MAXP;
    end
    if (v < -$signed({96'd0, MINN})) begin
      sat = 1'b1;
      return MINN;
    end
    return v[EW-1:0];
  endfunction

  function automatic inverse_t invert(matrix_t m);
    logic signed [127:0] a [3][3];
    logic signed [127:0] cof [3][3];
    logic signed [127:0] det;
    logic signed [127:0] num;
    logic sat;
    int r1, r2, c1, c2;
    inverse_t res;
    sat = 1'b0;
    res = '0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        a[r][c] = $signed(m[(r*3+c)*EW +: EW]);
    for (int r = 0; r < 3; r++) begin
      r1 = (r == 0) ? 1 : 0;
      r2 = (r == 2) ? 1 : 2;
      for (int c = 0; c < 3; c++) begin
        c1 = (c == 0) ? 1 : 0;
        c2 = (c == 2) ? 1 : 2;
        cof[r][c] = a[r1][c1] * a[r2][c2] - a[r1][c2] * a[r2][c1];
        if ((r + c) % 2 == 1) cof[r][c] = -cof[r][c];
      end
    end
    det = a[0][0] * cof[0][0] + a[0][1] * cof[0][1] + a[0][2] * cof[0][2];
    if (det == 0) begin
      res[10*EW] = 1'b1;
      return res;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        num = cof[c][r] <<< (2*FB);
        res[(r*3+c)*EW +: EW] = clip(num / det, sat);
      end
    res[9*EW +: EW] = clip(det / (128'sd1 <<< (2*FB)), sat);
    res[10*EW+1] = sat;
    return res;
  endfunction

  task automatic report(string what, int field, logic [EW-1:0] got, logic [EW-1:0] want);
    $display("mismatch at cycle %0d: %s field %0d got %h expected %h", cycle, what, field, got,
             want);
    errors++;
  endtask

  // input side: record expectations on every transfer
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst && s_tvalid && s_tready) expected_q.insert(expected_q.size(), invert(s_tdata));
  end

  // output side: compare against the oldest expectation
  always @(posedge clk) begin
    inverse_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        report("unexpected transfer", 0, m_tdata[EW-1:0], '0);
      end else begin
        want = expected_q.pop_front();
        for (int k = 0; k < 10; k++)
          if (m_tdata[k*EW +: EW] !== want[k*EW +: EW])
            report("data", k, m_tdata[k*EW +: EW], want[k*EW +: EW]);
        if (m_tuser[0] !== want[10*EW])
          report("singular", 10, EW'(m_tuser[0]), EW'(want[10*EW]));
        if (m_tuser[1] !== want[10*EW+1])
          report("saturated", 11, EW'(m_tuser[1]), EW'(want[10*EW+1]));
      end
    end
  end

  // hand-written results for the easy rows, checked against the predictor
  task automatic typed_row(matrix_t m, inverse_t want);
    inverse_t got;
    got = invert(m);
    if (got !== want) report("table row", 0, got[EW-1:0], want[EW-1:0]);
  endtask

  function automatic matrix_t diag(logic [EW-1:0] d, logic [EW-1:0] off);
    matrix_t m;
    for (int k = 0; k < 9; k++) m[k*EW +: EW] = (k % 4 == 0) ? d : off;
    return m;
  endfunction

  function automatic inverse_t diag_result(logic [EW-1:0] d, logic [EW-1:0] det, logic sat,
                                           logic sing);
    inverse_t r;
    r = '0;
    for (int k = 0; k < 9; k++) r[k*EW +: EW] = (k % 4 == 0) ? d : '0;
    r[9*EW +: EW] = det;
    r[10*EW] = sing;
    r[10*EW+1] = sat;
    return r;
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t m;
    int kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) begin
      case (kind)
        0, 1, 2: m[k*EW +: EW] = $urandom();
        3, 4, 5, 6: m[k*EW +: EW] = $signed($urandom_range(0, 16)) - 8 << FB | $urandom_range(0, 65535);
        7: m[k*EW +: EW] = $signed($urandom_range(0, 2000)) - 1000;
        default: m[k*EW +: EW] = ($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 3) - 1);
      endcase
    end
    // occasional repeated row for singular cases
    if ($urandom_range(0, 7) == 0) m[6*EW +: 3*EW] = m[0 +: 3*EW];
    return m;
  endfunction

  task automatic send(matrix_t m, bit idle_ok);
    int gap;
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= m;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // sink side: random stall bursts, one long hold-off, none near the end
  initial begin
    int len;
    bit held;
    held = 1'b0;
    @(negedge rst);
    @(posedge clk);
    while (1) begin
      if (!held && cycle >= 1500) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        len = $urandom_range(1, 13);
        m_tready <= 1'b0;
        repeat (len) @(posedge clk);
      end
      m_tready <= 1'b1;
      len = $urandom_range(1, 20);
      repeat (len) @(posedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    matrix_t table_m[$];
    inverse_t table_r[$];
    bit table_typed[$];
    matrix_t m;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    table_m.insert(table_m.size(), diag(ONE, '0));
    table_r.insert(table_r.size(), diag_result(ONE, ONE, 1'b0, 1'b0));
    table_typed.insert(table_typed.size(), 1'b1);
    table_m.insert(table_m.size(), '0);
    table_r.insert(table_r.size(), diag_result('0, '0, 1'b0, 1'b1));
    table_typed.insert(table_typed.size(), 1'b1);
    table_m.insert(table_m.size(), diag(2*ONE, '0));
    table_r.insert(table_r.size(), diag_result(32'h0000_8000, 32'h0008_0000, 1'b0, 1'b0));
    table_typed.insert(table_typed.size(), 1'b1);
    table_m.insert(table_m.size(), diag(-ONE, '0));
    table_r.insert(table_r.size(), diag_result(-ONE, -ONE, 1'b0, 1'b0));
    table_typed.insert(table_typed.size(), 1'b1);
    // tiny determinant: det field truncates to zero, inverse clips
    table_m.insert(table_m.size(), diag(32'd1, '0));
    table_r.insert(table_r.size(), diag_result(MAXP, '0, 1'b1, 1'b0));
    table_typed.insert(table_typed.size(), 1'b1);
    table_m.insert(table_m.size(), {9{MAXP}});
    table_r.insert(table_r.size(), diag_result('0, '0, 1'b0, 1'b1));
    table_typed.insert(table_typed.size(), 1'b1);
    table_m.insert(table_m.size(), {9{MINN}});
    table_r.insert(table_r.size(), diag_result('0, '0, 1'b0, 1'b1));
    table_typed.insert(table_typed.size(), 1'b1);
    table_m.insert(table_m.size(), {9{32'hffff_ffff}});
    table_r.insert(table_r.size(), diag_result('0, '0, 1'b0, 1'b1));
    table_typed.insert(table_typed.size(), 1'b1);
    table_m.insert(table_m.size(), diag(MAXP, '0));
    table_typed.insert(table_typed.size(), 1'b0);
    table_m.insert(table_m.size(), diag(MINN, '0));
    table_typed.insert(table_typed.size(), 1'b0);
    table_m.insert(table_m.size(), diag(MINN, MAXP));
    table_typed.insert(table_typed.size(), 1'b0);
    table_m.insert(table_m.size(), diag(32'hffff_ffff, 32'd1));
    table_typed.insert(table_typed.size(), 1'b0);
    table_m.insert(table_m.size(),
                   {MINN, 32'd1, MAXP, 32'hffff_ffff, ONE, -ONE, MAXP, MINN, 32'd3});
    table_typed.insert(table_typed.size(), 1'b0);
    table_m.insert(table_m.size(), diag(32'hffff_ffff, '0));
    table_typed.insert(table_typed.size(), 1'b0);
    table_m.insert(table_m.size(),
                   {ONE, 32'd5, 2*ONE, -ONE, 3*ONE, 32'd7, ONE, 4*ONE, 32'h1234_5678});
    table_typed.insert(table_typed.size(), 1'b0);

    foreach (table_m[i]) begin
      if (table_typed[i]) typed_row(table_m[i], table_r[i]);
      send(table_m[i], 1'b1);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - QUIET_TAIL) quiet = 1'b1;
      m = random_matrix();
      send(m, !quiet);
    end
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
